[rtl/core/rlfp_pkg.sv]
// ----------------------------------------------------------------------------
// rlfp_pkg
// Shared constants and types of the radio link frame parser.
// ----------------------------------------------------------------------------
package rlfp_pkg;

    localparam int DEFAULT_STORE_DEPTH = 16;
    localparam int FRAME_MAX           = 12;

    localparam logic [7:0] CFG_HEADER  = 8'hC0;
    localparam logic [7:0] CFG_TRAILER = 8'h40;
    localparam logic [7:0] HOP_B0      = 8'hFD;
    localparam logic [7:0] HOP_B1A     = 8'hD6;
    localparam logic [7:0] HOP_B1B     = 8'hD8;
    localparam logic [7:0] HOP_B2      = 8'h98;

    localparam logic [3:0] CFG_LAST_POS = 4'd5;
    localparam logic [3:0] HOP_LAST_POS = 4'd11;

    localparam logic [1:0] MODE_CFG = 2'd0;
    localparam logic [1:0] MODE_HOP = 2'd1;

    localparam logic KIND_CFG = 1'b0;
    localparam logic KIND_HOP = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [FRAME_MAX-1:0][7:0]  bytes;
    } frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } frame_push_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

[rtl/core/rlfp_front.sv]
// ----------------------------------------------------------------------------
// rlfp_front
// Byte parser: frame store, header and trailer matching, frame snapshot.
// ----------------------------------------------------------------------------
module rlfp_front #(
    parameter int STORE_DEPTH = rlfp_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_data,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output rlfp_pkg::frame_push_t push_out
);
    import rlfp_pkg::*;

    localparam int             PW       = $clog2(STORE_DEPTH);
    localparam logic [PW-1:0]  WRAP_POS = PW'(STORE_DEPTH - 1);

    // Only positions below FRAME_MAX are ever emitted; deeper entries are
    // seen by the header window through the two history bytes alone.
    logic [FRAME_MAX-1:0][7:0] frame_reg;
    logic [FRAME_MAX-1:0][7:0] frame_next;
    logic [PW-1:0]             wpos_reg;
    logic [PW-1:0]             wpos_next;
    logic                      hdr_reg;
    logic                      hdr_next;
    logic [7:0]                hist1_reg;
    logic [7:0]                hist2_reg;
    logic [7:0]                hist2_next;
    logic [1:0]                mode_reg;

    logic [PW-1:0]             pos;
    logic [PW-1:0]             pos_fin;
    logic                      emit;
    logic                      kind;

    always_comb
    begin
        pos        = (wpos_reg >= WRAP_POS) ? '0 : wpos_reg;
        frame_next = frame_reg;
        for (int i = 0; i < FRAME_MAX; i++)
        begin
            if (pos == PW'(i))
            begin
                frame_next[i] = rx_byte;
            end
        end
        hdr_next = hdr_reg;
        pos_fin  = pos;
        emit     = 1'b0;
        kind     = KIND_CFG;

        unique case (mode_reg)
            MODE_CFG:
            begin
                if (rx_byte == CFG_HEADER && !hdr_reg)
                begin
                    pos_fin       = '0;
                    frame_next[0] = CFG_HEADER;
                    hdr_next      = 1'b1;
                end
                if (pos_fin == PW'(CFG_LAST_POS) && hdr_next)
                begin
                    if (rx_byte == CFG_TRAILER)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        frame_next = '0;
                    end
                    pos_fin  = '0;
                    hdr_next = 1'b0;
                end
            end
            MODE_HOP:
            begin
                // hist2/hist1 hold the store entries two and one below pos
                if (pos >= PW'(2) && !hdr_reg && hist2_reg == HOP_B0 &&
                    (hist1_reg == HOP_B1A || hist1_reg == HOP_B1B) &&
                    rx_byte == HOP_B2)
                begin
                    frame_next[0] = HOP_B0;
                    frame_next[1] = hist1_reg;
                    frame_next[2] = HOP_B2;
                    pos_fin       = PW'(2);
                    hdr_next      = 1'b1;
                end
                if (pos_fin == PW'(HOP_LAST_POS) && hdr_next)
                begin
                    emit     = 1'b1;
                    kind     = KIND_HOP;
                    pos_fin  = '0;
                    hdr_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // Entry zero may be stale: pull it in when the next window starts there.
        hist2_next = (pos_fin == PW'(1)) ? frame_next[0] : hist1_reg;
        wpos_next  = pos_fin + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            wpos_reg  <= '0;
            hdr_reg   <= 1'b0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            mode_reg  <= MODE_CFG;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                frame_reg <= frame_next;
                wpos_reg  <= wpos_next;
                hdr_reg   <= hdr_next;
                hist1_reg <= rx_byte;
                hist2_reg <= hist2_next;
            end
        end
    end

    assign push_out.valid       = accept & emit;
    assign push_out.frame.kind  = kind;
    assign push_out.frame.bytes = frame_next;

endmodule

[rtl/core/rlfp_frame_queue.sv]
// ----------------------------------------------------------------------------
// rlfp_frame_queue
// Two-entry queue of whole frames between the parser and the serializer.
// ----------------------------------------------------------------------------
module rlfp_frame_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rlfp_pkg::frame_push_t   push_in,
    input  logic                    pop,
    output rlfp_pkg::frame_t        head,
    output rlfp_pkg::queue_status_t status
);
    import rlfp_pkg::*;

    frame_t     slot0_reg;
    frame_t     slot1_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push_in.valid && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push_in.valid && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_in.valid)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.valid && !wr_ptr_reg)
        begin
            slot0_reg <= push_in.frame;
        end
        if (push_in.valid && wr_ptr_reg)
        begin
            slot1_reg <= push_in.frame;
        end
    end

    assign head         = rd_ptr_reg ? slot1_reg : slot0_reg;
    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

[rtl/core/rlfp_back.sv]
// ----------------------------------------------------------------------------
// rlfp_back
// Frame serializer: sends one frame byte per beat from position 0 upward.
// ----------------------------------------------------------------------------
module rlfp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rlfp_pkg::frame_t  head,
    input  logic              head_valid,
    output logic              head_pop,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        frame_byte,
    output logic              frame_kind,
    output logic              last_of_frame
);
    import rlfp_pkg::*;

    logic [FRAME_MAX-1:0][7:0] data_reg;
    logic                      kind_reg;
    logic [3:0]                rem_reg;
    logic                      busy_reg;
    logic                      take;

    assign take     = pop & busy_reg;
    // Load the next frame while the last byte of this one leaves.
    assign head_pop = head_valid & (~busy_reg | (take & (rem_reg == 4'd0)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= 4'd0;
        end
        else if (head_pop)
        begin
            busy_reg <= 1'b1;
            rem_reg  <= (head.kind == KIND_HOP) ? HOP_LAST_POS : CFG_LAST_POS;
        end
        else if (take)
        begin
            if (rem_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                rem_reg <= rem_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            data_reg <= head.bytes;
            kind_reg <= head.kind;
        end
        else if (take)
        begin
            data_reg <= {8'h00, data_reg[FRAME_MAX-1:1]};
        end
    end

    assign empty         = ~busy_reg;
    assign frame_byte    = data_reg[0];
    assign frame_kind    = kind_reg;
    assign last_of_frame = (rem_reg == 4'd0);

endmodule

[rtl/core/radio_link_frame_parser.sv]
// ----------------------------------------------------------------------------
// radio_link_frame_parser
// Frame parser for bytes received from a radio module serial link.
// ----------------------------------------------------------------------------
// Input side is a queue: drive rx_byte with push; a beat is taken when push
// is high and full is low. One byte is taken per cycle while full is low;
// full rises only when two finished frames wait behind the one being sent.
// Output side is a queue: while empty is low, frame_byte, frame_kind and
// last_of_frame show the oldest frame byte; pop takes it. Bytes leave one
// per cycle while pop is high. The first byte of a frame shows once its closing
// byte is taken and the frame has passed the queue and serializer register,
// when no earlier frame is still leaving. A stalled receiver holds the current
// byte; input keeps flowing until the two-frame queue fills. link_mode is
// written through cfg_valid/cfg_data (cfg_ready stays high); the user must
// write it only while the block is idle, which the block does not enforce:
// 0 six-byte frames, 1 twelve-byte hop frames, 2 or 3 store only.
// Reset clears the frame store, write position, header flag and mode.
// ----------------------------------------------------------------------------
module radio_link_frame_parser #(
    parameter int STORE_DEPTH = rlfp_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] frame_byte,
    output logic       frame_kind,
    output logic       last_of_frame,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);
    import rlfp_pkg::*;

    frame_push_t   push_beat;
    frame_t        head;
    queue_status_t q_status;
    logic          head_pop;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign full      = q_status.full;
    assign accept    = push & ~q_status.full;

    rlfp_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .push_out (push_beat)
    );

    rlfp_frame_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push_beat),
        .pop     (head_pop),
        .head    (head),
        .status  (q_status)
    );

    rlfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (q_status.valid),
        .head_pop      (head_pop),
        .pop           (pop),
        .empty         (empty),
        .frame_byte    (frame_byte),
        .frame_kind    (frame_kind),
        .last_of_frame (last_of_frame)
    );

endmodule

[rtl/core/rlfp_checker.sv]
// ----------------------------------------------------------------------------
// rlfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module rlfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] frame_byte,
    input logic       frame_kind,
    input logic       last_of_frame
);
    import rlfp_pkg::*;

    logic [3:0] beat_cnt_reg;
    logic       kind_reg;

    // count beats within the frame on the output side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= 4'd0;
            kind_reg     <= KIND_CFG;
        end
        else if (pop && !empty)
        begin
            beat_cnt_reg <= last_of_frame ? 4'd0 : beat_cnt_reg + 4'd1;
            kind_reg     <= frame_kind;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_byte) &&
                              $stable(frame_kind) && $stable(last_of_frame)))
        else $error("stalled result beat changed");

    a_frame_length: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_of_frame ==
            (beat_cnt_reg == ((frame_kind == KIND_HOP) ? HOP_LAST_POS : CFG_LAST_POS))))
        else $error("frame end does not match frame length");

    a_kind_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && beat_cnt_reg != 4'd0) |-> (frame_kind == kind_reg))
        else $error("frame kind changed inside a frame");

    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without an input beat");

endmodule

bind radio_link_frame_parser rlfp_checker u_rlfp_checker (.*);
